// ===== sv/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation and status codes, and the reduction unit command.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned OpWidth         = 3;
  localparam int unsigned StatusWidth     = 2;
  localparam int unsigned ResNumWidth     = 33;
  localparam int unsigned ResDenWidth     = 31;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5,
    OP_LT  = 3'd6,
    OP_GT  = 3'd7
  } rau_op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } rau_status_e;

  typedef struct packed {
    logic start;
    logic narrow;
  } red_cmd_t;

endpackage

// ===== sv/rau_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul
// Registered unsigned magnitude multiplier shared by all cross products.
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int unsigned OperandWidth = rau_pkg::OperandWidthDef
) (
  input  logic                      clk_i,
  input  logic [OperandWidth-1:0]   a_i,
  input  logic [OperandWidth-1:0]   b_i,
  output logic [2*OperandWidth-1:0] p_o
);
  import rau_pkg::*;

  logic [2*OperandWidth-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== sv/rau_red.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_red
// Fraction reduction: binary gcd then two restoring divisions, all on one
// shared subtractor.
// ----------------------------------------------------------------------------
module rau_red #(
  parameter int unsigned OperandWidth = rau_pkg::OperandWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rau_pkg::red_cmd_t         cmd_i,
  input  logic [2*OperandWidth-1:0] num_i,
  input  logic [2*OperandWidth-1:0] den_i,
  output logic                      done_o,
  output logic [2*OperandWidth-1:0] num_o,
  output logic [2*OperandWidth-1:0] den_o
);
  import rau_pkg::*;

  localparam int unsigned W  = OperandWidth;
  localparam int unsigned MW = 2 * OperandWidth;
  localparam int unsigned CW = $clog2(MW + 1);

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001,
    U_EVEN = 6'b000010,
    U_GCD  = 6'b000100,
    U_DIVN = 6'b001000,
    U_DIVD = 6'b010000,
    U_DONE = 6'b100000
  } red_state_e;

  red_state_e    state_q, state_d;
  logic [MW-1:0] u_q, u_d, v_q, v_d;
  logic [MW-1:0] nq_q, nq_d, dq_q, dq_d;
  logic [MW-1:0] dvd_q, dvd_d, rem_q, rem_d;
  logic [MW-1:0] qn_q, qn_d, num_q, num_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d, len;
  logic          narrow_q, narrow_d;
  logic [MW:0]   sub_a, sub_b;
  logic [MW+1:0] diff;
  logic          borrow;
  logic [MW-1:0] dvd_shift, rem_next;

  function automatic logic [MW-1:0] align(input logic [MW-1:0] x, input logic nar);
    return nar ? {x[W-1:0], {W{1'b0}}} : x;
  endfunction

  // shared subtractor
  always_comb begin
    if (state_q == U_DIVN || state_q == U_DIVD) begin
      sub_a = {rem_q, dvd_q[MW-1]};
    end else begin
      sub_a = {1'b0, u_q};
    end
    sub_b = {1'b0, v_q};
  end

  assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow    = diff[MW+1];
  assign dvd_shift = {dvd_q[MW-2:0], ~borrow};
  assign rem_next  = borrow ? {rem_q[MW-2:0], dvd_q[MW-1]} : diff[MW-1:0];
  assign len       = narrow_q ? CW'(W) : CW'(MW);

  always_comb begin
    state_d  = state_q;
    u_d      = u_q;
    v_d      = v_q;
    nq_d     = nq_q;
    dq_d     = dq_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    qn_d     = qn_q;
    num_d    = num_q;
    den_d    = den_q;
    cnt_d    = cnt_q;
    narrow_d = narrow_q;
    unique case (state_q)
      U_IDLE: begin
        if (cmd_i.start) begin
          narrow_d = cmd_i.narrow;
          if (num_i == '0) begin
            num_d   = '0;
            den_d   = MW'(1);
            state_d = U_DONE;
          end else begin
            u_d     = num_i;
            v_d     = den_i;
            state_d = U_EVEN;
          end
        end
      end
      U_EVEN: begin
        if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
        end else begin
          nq_d    = u_q;
          dq_d    = v_q;
          state_d = U_GCD;
        end
      end
      U_GCD: begin
        if (u_q == '0) begin
          dvd_d   = align(nq_q, narrow_q);
          rem_d   = '0;
          cnt_d   = len;
          state_d = U_DIVN;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (borrow) begin
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = diff[MW-1:0];
        end
      end
      U_DIVN: begin
        rem_d = rem_next;
        dvd_d = dvd_shift;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          qn_d    = dvd_shift;
          dvd_d   = align(dq_q, narrow_q);
          rem_d   = '0;
          cnt_d   = len;
          state_d = U_DIVD;
        end
      end
      U_DIVD: begin
        rem_d = rem_next;
        dvd_d = dvd_shift;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          num_d   = qn_q;
          den_d   = dvd_shift;
          state_d = U_DONE;
        end
      end
      U_DONE: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q      <= u_d;
    v_q      <= v_d;
    nq_q     <= nq_d;
    dq_q     <= dq_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    qn_q     <= qn_d;
    num_q    <= num_d;
    den_q    <= den_d;
    cnt_q    <= cnt_d;
    narrow_q <= narrow_d;
  end

  assign done_o = (state_q == U_DONE);
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

// ===== sv/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply, divide and compare of two signed fractions.
// ----------------------------------------------------------------------------
// usage
// input channel: operation_i and the four operand fields with in_valid_i;
//   a transaction is taken when in_valid_i is high and in_stall_o is low
// output channel: reduced result with out_valid_o; taken when out_stall_i is low
// one transaction at a time: in_stall_o stays high from acceptance until the
//   result has been moved into the output register
// sequence: a zero denominator goes from acceptance straight to the final
//   state and from there into the output register; otherwise each operand
//   reduction goes straight to done for a zero numerator, else it removes
//   shared factors of two, runs the gcd steps and two n-bit divisions
//   (n = OPERAND_WIDTH), then a check state, the multiply and combine states
//   except for equal and not equal, and for arithmetic one more reduction with
//   n = 2*OPERAND_WIDTH
// the time is set mainly by the reduction unit and its one shared subtractor
// a new transaction is taken only once the last has left the final state; the
//   next transaction can start while a finished result still waits in the
//   output register
// a stalled receiver holds the result; the next result then waits in the
//   final state until the output register frees
// reset clears the sequencer and the output valid, no clearing pass is needed
// ----------------------------------------------------------------------------
module rational_arith_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rau_pkg::OpWidth-1:0]     operation_i,
  input  logic [OPERAND_WIDTH-1:0]        a_num_i,
  input  logic [OPERAND_WIDTH-1:0]        a_den_i,
  input  logic [OPERAND_WIDTH-1:0]        b_num_i,
  input  logic [OPERAND_WIDTH-1:0]        b_den_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rau_pkg::ResNumWidth-1:0] res_num_o,
  output logic [rau_pkg::ResDenWidth-1:0] res_den_o,
  output logic                            cmp_true_o,
  output logic [rau_pkg::StatusWidth-1:0] status_o
);
  import rau_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned MW = 2 * OPERAND_WIDTH;
  localparam int unsigned NW = (MW + 1 > ResNumWidth) ? MW + 1 : ResNumWidth;
  localparam int unsigned DW = (MW > ResDenWidth) ? MW : ResDenWidth;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RED_A = 11'b00000000010,
    S_RED_B = 11'b00000000100,
    S_CHECK = 11'b00000001000,
    S_MUL0  = 11'b00000010000,
    S_MUL1  = 11'b00000100000,
    S_MUL2  = 11'b00001000000,
    S_MUL3  = 11'b00010000000,
    S_COMB  = 11'b00100000000,
    S_RED_R = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } seq_state_e;

  seq_state_e  state_q, state_d;
  rau_op_e     op_q, op_d;
  logic [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0] am_q, am_d, adm_q, adm_d, bm_q, bm_d, bdm_q, bdm_d;
  logic         sa_q, sa_d, sb_q, sb_d;
  logic [MW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [MW-1:0] wn_q, wn_d, wd_q, wd_d;
  logic          wneg_q, wneg_d, wcmp_q, wcmp_d;
  rau_status_e   wst_q, wst_d;
  logic          start_q, start_d;

  logic                   out_valid_q, out_valid_d;
  logic [ResNumWidth-1:0] res_num_q, res_num_d;
  logic [ResDenWidth-1:0] res_den_q, res_den_d;
  logic                   cmp_q, cmp_d;
  rau_status_e            st_q, st_d;

  logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
  red_cmd_t      red_cmd;
  logic [MW-1:0] red_num, red_den, red_num_o, red_den_o;
  logic          red_done;
  logic [W-1:0]  mul_a, mul_b;
  logic [MW-1:0] mul_p;
  logic [MW:0]   xs, ys, sum, sum_abs;
  logic          lt, gt;
  logic [NW-1:0] num_ext, num_sgn;
  logic [DW-1:0] den_ext;
  logic          out_free;

  assign an_mag = an_q[W-1] ? -an_q : an_q;
  assign ad_mag = ad_q[W-1] ? -ad_q : ad_q;
  assign bn_mag = bn_q[W-1] ? -bn_q : bn_q;
  assign bd_mag = bd_q[W-1] ? -bd_q : bd_q;

  // reduction unit operand select
  always_comb begin
    red_cmd.start  = start_q;
    red_cmd.narrow = (state_q != S_RED_R);
    if (state_q == S_RED_A) begin
      red_num = MW'(an_mag);
      red_den = MW'(ad_mag);
    end else if (state_q == S_RED_B) begin
      red_num = MW'(bn_mag);
      red_den = MW'(bd_mag);
    end else begin
      red_num = wn_q;
      red_den = wd_q;
    end
  end

  rau_red #(
    .OperandWidth(OPERAND_WIDTH)
  ) u_red (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (red_cmd),
    .num_i (red_num),
    .den_i (red_den),
    .done_o(red_done),
    .num_o (red_num_o),
    .den_o (red_den_o)
  );

  // cross product select
  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = bm_q;
      mul_b = adm_q;
    end else if (state_q == S_MUL2) begin
      mul_a = adm_q;
      mul_b = (op_q == OP_DIV) ? bm_q : bdm_q;
    end else begin
      mul_a = am_q;
      mul_b = (op_q == OP_MUL) ? bm_q : bdm_q;
    end
  end

  rau_mul #(
    .OperandWidth(OPERAND_WIDTH)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign xs      = sa_q ? -{1'b0, x_q} : {1'b0, x_q};
  assign ys      = (sb_q ^ (op_q == OP_SUB)) ? -{1'b0, y_q} : {1'b0, y_q};
  assign sum     = xs + ys;
  assign sum_abs = sum[MW] ? -sum : sum;
  assign lt      = $signed(xs) < $signed(ys);
  assign gt      = $signed(ys) < $signed(xs);

  assign num_ext  = NW'(wn_q);
  assign num_sgn  = (wneg_q && (wn_q != '0)) ? -num_ext : num_ext;
  assign den_ext  = DW'(wd_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    am_d        = am_q;
    adm_d       = adm_q;
    bm_d        = bm_q;
    bdm_d       = bdm_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    wn_d        = wn_q;
    wd_d        = wd_q;
    wneg_d      = wneg_q;
    wcmp_d      = wcmp_q;
    wst_d       = wst_q;
    start_d     = 1'b0;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    cmp_d       = cmp_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = rau_op_e'(operation_i);
          an_d   = a_num_i;
          ad_d   = a_den_i;
          bn_d   = b_num_i;
          bd_d   = b_den_i;
          wn_d   = '0;
          wd_d   = MW'(1);
          wneg_d = 1'b0;
          wcmp_d = 1'b0;
          if (a_den_i == '0 || b_den_i == '0) begin
            wst_d   = ST_ZERO_DEN;
            state_d = S_DONE;
          end else begin
            wst_d   = ST_OK;
            start_d = 1'b1;
            state_d = S_RED_A;
          end
        end
      end
      S_RED_A: begin
        if (red_done) begin
          am_d    = red_num_o[W-1:0];
          adm_d   = red_den_o[W-1:0];
          sa_d    = (an_q[W-1] ^ ad_q[W-1]) && (red_num_o != '0);
          start_d = 1'b1;
          state_d = S_RED_B;
        end
      end
      S_RED_B: begin
        if (red_done) begin
          bm_d    = red_num_o[W-1:0];
          bdm_d   = red_den_o[W-1:0];
          sb_d    = (bn_q[W-1] ^ bd_q[W-1]) && (red_num_o != '0);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_q == OP_DIV && bm_q == '0) begin
          wst_d   = ST_DIV_ZERO;
          state_d = S_DONE;
        end else if (op_q == OP_EQ || op_q == OP_NE) begin
          wcmp_d  = (am_q == bm_q && sa_q == sb_q && adm_q == bdm_q) ^ (op_q == OP_NE);
          state_d = S_DONE;
        end else begin
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        state_d = S_MUL1;
      end
      S_MUL1: begin
        x_d     = mul_p;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        y_d     = mul_p;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        z_d     = mul_p;
        state_d = S_COMB;
      end
      S_COMB: begin
        unique case (op_q)
          OP_ADD, OP_SUB: begin
            wn_d    = sum_abs[MW-1:0];
            wneg_d  = sum[MW];
            wd_d    = z_q;
            start_d = 1'b1;
            state_d = S_RED_R;
          end
          OP_MUL, OP_DIV: begin
            wn_d    = x_q;
            wneg_d  = sa_q ^ sb_q;
            wd_d    = z_q;
            start_d = 1'b1;
            state_d = S_RED_R;
          end
          OP_LT: begin
            wcmp_d  = lt;
            state_d = S_DONE;
          end
          OP_GT: begin
            wcmp_d  = gt;
            state_d = S_DONE;
          end
          OP_EQ, OP_NE: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RED_R: begin
        if (red_done) begin
          wn_d    = red_num_o;
          wd_d    = red_den_o;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_num_d   = num_sgn[ResNumWidth-1:0];
          res_den_d   = den_ext[ResDenWidth-1:0];
          cmp_d       = wcmp_q;
          st_d        = wst_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    am_q      <= am_d;
    adm_q     <= adm_d;
    bm_q      <= bm_d;
    bdm_q     <= bdm_d;
    sa_q      <= sa_d;
    sb_q      <= sb_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    wn_q      <= wn_d;
    wd_q      <= wd_d;
    wneg_q    <= wneg_d;
    wcmp_q    <= wcmp_d;
    wst_q     <= wst_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    cmp_q     <= cmp_d;
    st_q      <= st_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign cmp_true_o  = cmp_q;
  assign status_o    = st_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted transaction did not raise in_stall_o");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      res_num_o == '0 && res_den_o == ResDenWidth'(1) && !cmp_true_o)
    else $error("error result carries nonzero fields");

  a_cmp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cmp_true_o |-> res_num_o == '0 && res_den_o == ResDenWidth'(1))
    else $error("comparison result carries a fraction");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> res_den_o != '0)
    else $error("result denominator is zero");

  a_red_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> state_q == S_RED_A || state_q == S_RED_B || state_q == S_RED_R)
    else $error("reduction finished outside a reduction step");
`endif

endmodule
